>>> rtl/well_pkg.sv
// types, microcode table and bit functions shared by the well1024a generator
`default_nettype none
package well_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RingD  = 32;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned ThrW   = 33;

  localparam logic [IdxW-1:0]  TapM1    = IdxW'(3);
  localparam logic [IdxW-1:0]  TapM2    = IdxW'(24);
  localparam logic [IdxW-1:0]  TapM3    = IdxW'(10);
  localparam logic [WordW-1:0] SeedMult = 32'd1812433253;

  localparam logic CmdGenerate = 1'b0;
  localparam logic CmdReseed   = 1'b1;

  typedef struct packed {
    logic            command;
    logic [ThrW-1:0] threshold;
  } in_req_t;

  typedef struct packed {
    logic [WordW-1:0] random_word;
    logic             below_threshold;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_G0,
    S_G1,
    S_G2,
    S_G3,
    S_G4,
    S_R0,
    S_R1
  } step_t;

  typedef enum logic [1:0] {
    RDA_TAP1,
    RDA_TAP3,
    RDA_LAST
  } rda_sel_t;

  typedef enum logic {
    RDB_TAP2,
    RDB_CUR
  } rdb_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CUR,
    WR_LAST,
    WR_SEED
  } wr_sel_t;

  typedef struct packed {
    rda_sel_t rda;
    rdb_sel_t rdb;
    logic     cap_ab;
    logic     cap_z;
    logic     cap_res;
    wr_sel_t  wr;
    logic     emit;
    logic     seed_load;
    logic     loop;
    step_t    nxt;
  } ctl_t;

  typedef struct packed {
    logic cnt_last;
    logic out_blocked;
  } dp_sts_t;

  function automatic ctl_t ctl_rom(step_t s);
    ctl_t c;
    c = '{rda: RDA_TAP1, rdb: RDB_TAP2, cap_ab: 1'b0, cap_z: 1'b0, cap_res: 1'b0,
          wr: WR_NONE, emit: 1'b0, seed_load: 1'b0, loop: 1'b0, nxt: S_IDLE};
    case (s)
      S_G0: begin
        c.rda = RDA_TAP1;
        c.rdb = RDB_TAP2;
        c.nxt = S_G1;
      end
      S_G1: begin
        c.rda    = RDA_TAP3;
        c.rdb    = RDB_CUR;
        c.cap_ab = 1'b1;
        c.nxt    = S_G2;
      end
      S_G2: begin
        c.rda   = RDA_LAST;
        c.cap_z = 1'b1;
        c.nxt   = S_G3;
      end
      S_G3: begin
        c.cap_res = 1'b1;
        c.wr      = WR_CUR;
        c.nxt     = S_G4;
      end
      S_G4: begin
        c.wr   = WR_LAST;
        c.emit = 1'b1;
        c.nxt  = S_IDLE;
      end
      S_R0: begin
        c.seed_load = 1'b1;
        c.nxt       = S_R1;
      end
      S_R1: begin
        c.wr   = WR_SEED;
        c.loop = 1'b1;
        c.nxt  = S_IDLE;
      end
      default: begin
        c.nxt = S_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic [WordW-1:0] xor_rsh(logic [WordW-1:0] v, int unsigned s);
    return v ^ (v >> s);
  endfunction

  function automatic logic [WordW-1:0] xor_lsh(logic [WordW-1:0] v, int unsigned s);
    return v ^ (v << s);
  endfunction

endpackage
`default_nettype wire

>>> rtl/well_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none
module well_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_a,
  output logic      [Width-1:0]         rd_data_a,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_b,
  output logic      [Width-1:0]         rd_data_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

>>> rtl/well_seq.sv
// microcode sequencer: step counter, control rom and jumps
`default_nettype none
module well_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_command,
  output logic                   in_stall,
  output logic                   in_take,
  input  wire well_pkg::dp_sts_t sts,
  output well_pkg::ctl_t         ctl
);
  import well_pkg::*;

  step_t step_r;
  step_t step_nxt;
  ctl_t  rom_w;
  logic  hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    rom_w    = ctl_rom(step_r);
    in_stall = (step_r != S_IDLE);
    in_take  = in_valid && !in_stall;
    hold     = rom_w.emit && sts.out_blocked;
    ctl      = rom_w;
    step_nxt = step_r;
    if (step_r == S_IDLE) begin
      if (in_take) begin
        step_nxt = (in_command == CmdReseed) ? S_R0 : S_G0;
      end
    end else if (hold) begin
      ctl.emit = 1'b0;
      ctl.wr   = WR_NONE;
    end else if (rom_w.loop && !sts.cnt_last) begin
      step_nxt = step_r;
    end else begin
      step_nxt = rom_w.nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/well_dp.sv
// datapath: ring memory, index, tap registers, seed multiplier, output register
`default_nettype none
module well_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire well_pkg::ctl_t              ctl,
  output well_pkg::dp_sts_t                sts,
  input  wire logic                        in_take,
  input  wire logic [well_pkg::ThrW-1:0]   in_threshold,
  input  wire logic                        cfg_write_en,
  input  wire logic [well_pkg::WordW-1:0]  cfg_write_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output well_pkg::out_rsp_t               out_rsp
);
  import well_pkg::*;

  logic [WordW-1:0] seed_r;
  logic [IdxW-1:0]  index_r;
  logic [IdxW-1:0]  cnt_r;
  logic [WordW-1:0] prev_r;
  logic [WordW-1:0] a_r, b_r, z1_r, z2_r, res_r;
  logic [ThrW-1:0]  thr_r;
  logic             seeded_r;
  logic             out_valid_r;
  out_rsp_t         out_r;

  logic [IdxW-1:0]  last_idx;
  logic [IdxW-1:0]  rd_addr_a, rd_addr_b;
  logic [WordW-1:0] rd_data_a, rd_data_b;
  logic [WordW-1:0] da, db;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [WordW-1:0] wr_data;
  logic [IdxW-1:0]  cnt_inc;
  logic [WordW-1:0] prev_nxt;

  well_ram #(
    .Width(WordW),
    .Depth(RingD)
  ) u_ring (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_data_a(rd_data_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_b(rd_data_b)
  );

  always_comb begin
    last_idx = index_r - IdxW'(1);
    cnt_inc  = cnt_r + IdxW'(1);
    case (ctl.rda)
      RDA_TAP1: rd_addr_a = index_r + TapM1;
      RDA_TAP3: rd_addr_a = index_r + TapM3;
      RDA_LAST: rd_addr_a = last_idx;
      default:  rd_addr_a = index_r;
    endcase
    case (ctl.rdb)
      RDB_TAP2: rd_addr_b = index_r + TapM2;
      RDB_CUR:  rd_addr_b = index_r;
      default:  rd_addr_b = index_r;
    endcase
    // ring reads as zero until the first reseed
    da = seeded_r ? rd_data_a : '0;
    db = seeded_r ? rd_data_b : '0;
    wr_en   = 1'b1;
    wr_addr = index_r;
    wr_data = z1_r ^ z2_r;
    case (ctl.wr)
      WR_NONE: wr_en = 1'b0;
      WR_CUR: begin
        wr_addr = index_r;
        wr_data = z1_r ^ z2_r;
      end
      WR_LAST: begin
        wr_addr = last_idx;
        wr_data = res_r;
      end
      WR_SEED: begin
        wr_addr = cnt_r;
        wr_data = prev_r;
      end
      default: wr_en = 1'b0;
    endcase
    prev_nxt = (SeedMult * (prev_r ^ (prev_r >> 30))) + WordW'(cnt_inc);
    sts.cnt_last    = (cnt_r == '1);
    sts.out_blocked = out_valid_r && out_stall;
    out_valid = out_valid_r;
    out_rsp   = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      index_r     <= '0;
      cnt_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        seed_r <= cfg_write_data;
      end
      if (ctl.seed_load) begin
        cnt_r    <= '0;
        index_r  <= '0;
        seeded_r <= 1'b1;
      end
      if (ctl.wr == WR_SEED) begin
        cnt_r <= cnt_inc;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
        index_r     <= last_idx;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      thr_r <= in_threshold;
    end
    if (ctl.seed_load) begin
      prev_r <= seed_r;
    end
    if (ctl.wr == WR_SEED) begin
      prev_r <= prev_nxt;
    end
    if (ctl.cap_ab) begin
      a_r <= xor_rsh(da, 8);
      b_r <= xor_lsh(db, 19);
    end
    if (ctl.cap_z) begin
      z2_r <= b_r ^ xor_lsh(da, 14);
      z1_r <= db ^ a_r;
    end
    if (ctl.cap_res) begin
      res_r <= xor_lsh(da, 11) ^ xor_lsh(z1_r, 7) ^ xor_lsh(z2_r, 13);
    end
    if (ctl.emit) begin
      out_r.random_word     <= res_r;
      out_r.below_threshold <= ({1'b0, res_r} <= thr_r);
    end
  end

endmodule
`default_nettype wire

>>> rtl/well1024a_random_generator.sv
// top level of the well1024a random word generator
// Usage:
//   Input channel (in_valid, in_stall, in_req) takes one request at a time:
//   command generate returns one result, command reseed returns none.
//   Result channel (out_valid, out_stall, out_rsp) carries the new word as a
//   0.32 fraction and a flag set when it is at most the request's threshold.
//   cfg_write_en/cfg_write_data write seed register; user rule: idle, unchecked.
// Timing:
//   generate: taken in the idle step, then steps G0 to G4 register the result;
//   the next one waits for idle, set by the single write port of the ring ram
//   and the microcode program stepping through its five reads and two writes.
//   reseed: one ring word per cycle through the seed multiplier.
// Reset:
//   seed register, index and output valid clear; the ring reads as zeros
//   until the first reseed. No clearing pass.
// Back-pressure:
//   a finished result waits in the output register; the next request is
//   taken meanwhile and only its last step waits while the output is stalled.
`default_nettype none
module well1024a_random_generator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire well_pkg::in_req_t          in_req,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output well_pkg::out_rsp_t              out_rsp,
  input  wire logic                       cfg_write_en,
  input  wire logic [well_pkg::WordW-1:0] cfg_write_data
);
  import well_pkg::*;

  ctl_t    ctl;
  dp_sts_t sts;
  logic    in_take;

  well_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_req.command),
    .in_stall  (in_stall),
    .in_take   (in_take),
    .sts       (sts),
    .ctl       (ctl)
  );

  well_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_take       (in_take),
    .in_threshold  (in_req.threshold),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rsp       (out_rsp)
  );

endmodule
`default_nettype wire

>>> rtl/well_chk.sv
// port-level assertions for the well1024a generator and their bind
`default_nettype none
module well_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire well_pkg::in_req_t          in_req,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire well_pkg::out_rsp_t         out_rsp,
  input wire logic                       cfg_write_en,
  input wire logic [well_pkg::WordW-1:0] cfg_write_data
);
  import well_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // no result survives reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request taken while busy");

  // a new result appears only while a request is being worked on
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request");

  // reseed keeps the input side busy at the start and at the last step of the ring fill
  a_reseed_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req.command == CmdReseed) |=> in_stall ##32 in_stall)
    else $error("reseed finished early");

  logic unused_cfg;
  assign unused_cfg = cfg_write_en ^ (^cfg_write_data);

endmodule

bind well1024a_random_generator well_chk u_chk (.*);
`default_nettype wire
